>>> rtl/wctf_pkg.sv
package wctf_pkg;

  // Angle unit is 1/64 degree.
  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;

  // Reduced angle fits in 15 bits (0..23039).
  localparam int ANGLE_RED_W = 15;

  // floor(2^30 / 23040); the quotient estimate is low by at most one.
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_TURN  = 46603;

  localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;
  localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;

  localparam int CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CAMERA_X    = 3'd0,
    REG_CAMERA_Y    = 3'd1,
    REG_CAMERA_Z    = 3'd2,
    REG_YAW_ANGLE   = 3'd3,
    REG_PITCH_ANGLE = 3'd4,
    REG_ROLL_ANGLE  = 3'd5
  } cfg_reg_e;

  // Sine in Q28 of x in [0, pi] (x in Q28), Taylor series, clamped to [0, 1].
  // Used only to build the constant sine table.
  function automatic logic signed [63:0] sine_q28(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 28;
    term = x;
    sum  = signed'(x);
    for (int k = 1; k <= 13; k++) begin
      term = ((term * x2) >> 28) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > ONE_Q28) begin
      sum = ONE_Q28;
    end
    return sum;
  endfunction

endpackage

>>> rtl/wctf_trig.sv
module wctf_trig import wctf_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int COORD_FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic [15:0]                       angle,
  output logic signed [COORD_FRAC_BITS+1:0] sin_val,
  output logic signed [COORD_FRAC_BITS+1:0] cos_val
);

  localparam int SW = COORD_FRAC_BITS + 2;
  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam int PW = ANGLE_RED_W + $clog2(SINE_TABLE_DEPTH + 1);
  localparam int QW = PW + 16;

  localparam logic signed [17:0] FULL_S    = 18'(FULL_TURN);
  localparam logic signed [17:0] QUARTER_S = 18'(QUARTER_TURN);

  // Constant sine table over one full turn.
  logic signed [SW-1:0] rom [SINE_TABLE_DEPTH];

  for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam bit NEG = (2 * i) > SINE_TABLE_DEPTH;
    localparam logic [63:0] M = NEG ? 64'(SINE_TABLE_DEPTH - i) : 64'(i);
    localparam logic [63:0] XQ =
      (M * TWO_PI_Q28 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] VQ = 64'(sine_q28(XQ));
    localparam logic [63:0] RQ =
      (VQ + (64'd1 << (27 - COORD_FRAC_BITS))) >> (28 - COORD_FRAC_BITS);
    localparam logic signed [SW-1:0] RV = SW'(RQ);
    assign rom[i] = NEG ? -RV : RV;
  end

  // Lane 0 is sine, lane 1 is cosine.
  logic signed [17:0]     n0, n1, n2, n3, c0;
  logic [ANGLE_RED_W-1:0] red_next [2];

  logic [ANGLE_RED_W-1:0] red   [2];
  logic [PW-1:0]          prod  [2];
  logic [PW-1:0]          prod3 [2];
  logic [IW:0]            quot  [2];
  logic [IW-1:0]          idx   [2];

  // Negate and reduce modulo a full turn.
  always_comb begin
    n0 = -(18'(signed'(angle)));
    n1 = (n0 < 0) ? n0 + FULL_S : n0;
    n2 = (n1 < 0) ? n1 + FULL_S : n1;
    n3 = (n2 >= FULL_S) ? n2 - FULL_S : n2;
    c0 = n3 + QUARTER_S;
    if (c0 >= FULL_S) begin
      c0 = c0 - FULL_S;
    end
    red_next[0] = ANGLE_RED_W'(n3);
    red_next[1] = ANGLE_RED_W'(c0);
  end

  logic [QW-1:0] rq    [2];
  logic [PW-1:0] chk   [2];
  logic [PW-1:0] rem   [2];
  logic [IW:0]   qfix  [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rq[l]   = QW'(prod[l]) * QW'(RECIP_TURN);
      chk[l]  = PW'(quot[l]) * PW'(FULL_TURN);
      rem[l]  = prod3[l] - chk[l];
      qfix[l] = (rem[l] >= PW'(FULL_TURN)) ? quot[l] + 1'b1 : quot[l];
    end
  end

  // Table index = floor(a * DEPTH / FULL_TURN): scale, reciprocal, fix up.
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      red[l]   <= red_next[l];
      prod[l]  <= PW'(red[l]) * PW'(SINE_TABLE_DEPTH);
      quot[l]  <= (IW + 1)'(rq[l] >> RECIP_SHIFT);
      prod3[l] <= prod[l];
      idx[l]   <= IW'(qfix[l]);
    end
    sin_val <= rom[idx[0]];
    cos_val <= rom[idx[1]];
  end

endmodule

>>> rtl/wctf_rot.sv
module wctf_rot #(
  parameter int COORD_FRAC_BITS = 16,
  parameter bit NEG_FIRST       = 1'b0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              bypass,
  input  logic signed [COORD_FRAC_BITS+1:0] sin_val,
  input  logic signed [COORD_FRAC_BITS+1:0] cos_val,
  input  logic signed [31:0]                p_in,
  input  logic signed [31:0]                q_in,
  input  logic signed [31:0]                r_in,
  output logic                              out_valid,
  output logic signed [31:0]                p_out,
  output logic signed [31:0]                q_out,
  output logic signed [31:0]                r_out
);

  localparam int SW  = COORD_FRAC_BITS + 2;
  localparam int PRW = 32 + SW;
  localparam logic signed [PRW-1:0] RND = PRW'(2 ** (COORD_FRAC_BITS - 1));

  // p' = p*c +/- q*s, q' = q*c -/+ p*s
  logic                  v_a, byp_a;
  logic signed [31:0]    p_a, q_a, r_a;
  logic signed [PRW-1:0] pc_a, qs_a, qc_a, ps_a;
  logic signed [PRW-1:0] sum_p, sum_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_a       <= in_valid;
      out_valid <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    byp_a <= bypass;
    p_a   <= p_in;
    q_a   <= q_in;
    r_a   <= r_in;
    pc_a  <= PRW'(p_in) * PRW'(cos_val);
    qs_a  <= PRW'(q_in) * PRW'(sin_val);
    qc_a  <= PRW'(q_in) * PRW'(cos_val);
    ps_a  <= PRW'(p_in) * PRW'(sin_val);
  end

  always_comb begin
    if (NEG_FIRST) begin
      sum_p = pc_a - qs_a + RND;
      sum_q = qc_a + ps_a + RND;
    end else begin
      sum_p = pc_a + qs_a + RND;
      sum_q = qc_a - ps_a + RND;
    end
  end

  // Round, floor shift, wrap to 32 bits.
  always_ff @(posedge clk) begin
    p_out <= byp_a ? p_a : sum_p[COORD_FRAC_BITS+31:COORD_FRAC_BITS];
    q_out <= byp_a ? q_a : sum_q[COORD_FRAC_BITS+31:COORD_FRAC_BITS];
    r_out <= r_a;
  end

endmodule

>>> rtl/world_to_camera_transform_unit.sv
// Channel   | Direction | Handshake                     | Payload
// ----------+-----------+-------------------------------+---------------------------------
// vertex    | in        | start & !busy                 | world_x, world_y, world_z
// result    | out       | done, one cycle, no backpress | view_x, view_y, view_z
// config    | in        | cfg_valid & cfg_ready         | cfg_addr, cfg_wdata
//
// Takes one item every clock while busy is low; results follow in order, one
// done pulse per item.
// Pipeline: one stage for the camera offset, then two per rotation (multiply,
// then add/round/shift) for yaw, pitch and roll.
// busy is high during reset and, after reset or any config write, while the
// 5-stage sine/cosine index pipeline refreshes from the new angles.
// The receiver cannot stall, so the pipeline always advances.
module world_to_camera_transform_unit import wctf_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int COORD_FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    world_x,
  input  logic signed [31:0]    world_y,
  input  logic signed [31:0]    world_z,
  output logic                  done,
  output logic signed [31:0]    view_x,
  output logic signed [31:0]    view_y,
  output logic signed [31:0]    view_z,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]           cfg_wdata
);

  localparam int SW = COORD_FRAC_BITS + 2;
  // Cycles to hold off items until the trig outputs reflect the registers.
  localparam logic [2:0] SETTLE = 3'd4;

  logic signed [31:0] camera_x, camera_y, camera_z;
  logic [15:0]        yaw_angle, pitch_angle, roll_angle;
  logic [2:0]         settle_cnt;
  logic               cfg_write;

  assign cfg_ready = !rst;
  assign cfg_write = cfg_valid && cfg_ready;
  assign busy      = rst || (settle_cnt != '0);

  // Configuration registers; writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x    <= '0;
      camera_y    <= '0;
      camera_z    <= '0;
      yaw_angle   <= '0;
      pitch_angle <= '0;
      roll_angle  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_addr)
        REG_CAMERA_X:    camera_x    <= cfg_wdata;
        REG_CAMERA_Y:    camera_y    <= cfg_wdata;
        REG_CAMERA_Z:    camera_z    <= cfg_wdata;
        REG_YAW_ANGLE:   yaw_angle   <= cfg_wdata[15:0];
        REG_PITCH_ANGLE: pitch_angle <= cfg_wdata[15:0];
        REG_ROLL_ANGLE:  roll_angle  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Hold busy while the trig pipeline catches up with new angles.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      settle_cnt <= SETTLE;
    end else if (settle_cnt != '0) begin
      settle_cnt <= settle_cnt - 3'd1;
    end
  end

  // Sine and cosine of the negated angle, one unit per axis.
  logic signed [SW-1:0] yaw_sin, yaw_cos, pitch_sin, pitch_cos, roll_sin, roll_cos;

  wctf_trig #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_trig_yaw (
    .clk    (clk),
    .angle  (yaw_angle),
    .sin_val(yaw_sin),
    .cos_val(yaw_cos)
  );

  wctf_trig #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_trig_pitch (
    .clk    (clk),
    .angle  (pitch_angle),
    .sin_val(pitch_sin),
    .cos_val(pitch_cos)
  );

  wctf_trig #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_trig_roll (
    .clk    (clk),
    .angle  (roll_angle),
    .sin_val(roll_sin),
    .cos_val(roll_cos)
  );

  // Stage 1: move the origin to the camera (wraps modulo 2^32).
  logic               v1;
  logic signed [31:0] x1, y1, z1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    x1 <= world_x - camera_x;
    y1 <= world_y - camera_y;
    z1 <= world_z - camera_z;
  end

  // Yaw about Y: x' = x*c + z*s, z' = z*c - x*s.
  logic               v3;
  logic signed [31:0] x3, y3, z3;

  wctf_rot #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .NEG_FIRST      (1'b0)
  ) u_rot_yaw (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .bypass   (yaw_angle == '0),
    .sin_val  (yaw_sin),
    .cos_val  (yaw_cos),
    .p_in     (x1),
    .q_in     (z1),
    .r_in     (y1),
    .out_valid(v3),
    .p_out    (x3),
    .q_out    (z3),
    .r_out    (y3)
  );

  // Pitch about X: y' = y*c - z*s, z' = z*c + y*s.
  logic               v5;
  logic signed [31:0] x5, y5, z5;

  wctf_rot #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .NEG_FIRST      (1'b1)
  ) u_rot_pitch (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .bypass   (pitch_angle == '0),
    .sin_val  (pitch_sin),
    .cos_val  (pitch_cos),
    .p_in     (y3),
    .q_in     (z3),
    .r_in     (x3),
    .out_valid(v5),
    .p_out    (y5),
    .q_out    (z5),
    .r_out    (x5)
  );

  // Roll about Z: x' = x*c - y*s, y' = y*c + x*s. Its output registers are the
  // result ports.
  wctf_rot #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .NEG_FIRST      (1'b1)
  ) u_rot_roll (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v5),
    .bypass   (roll_angle == '0),
    .sin_val  (roll_sin),
    .cos_val  (roll_cos),
    .p_in     (x5),
    .q_in     (y5),
    .r_in     (z5),
    .out_valid(done),
    .p_out    (view_x),
    .q_out    (view_y),
    .r_out    (view_z)
  );

  // Every accepted item comes out on done once it has passed the camera stage and all three rotations.
  a_item_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##7 done)
    else $error("accepted item did not complete on time");

  // No result without a matching accepted item.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 7))
    else $error("result without a matching accepted item");

  // A config write must block items until the trig values settle.
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> busy)
    else $error("items accepted right after a config write");

endmodule
